### hdl/frpc_pkg.sv
// shared types and constants for the framed packet receiver
// no dependencies
`default_nettype none

package frpc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] FRAME_ID_RST   = 8'h00;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 16'hFFFF;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

	typedef enum logic [4:0] {
		PH_ID     = 5'b00001,
		PH_LEN_LO = 5'b00010,
		PH_LEN_HI = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_CHK    = 5'b10000
	} phase_t;

	typedef enum logic [STAT_W-1:0] {
		ST_BUSY    = 3'd0,
		ST_DONE    = 3'd1,
		ST_BAD_ID  = 3'd2,
		ST_TOOLONG = 3'd3,
		ST_BAD_SUM = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_id;
		logic [LEN_W-1:0]  max_length;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] payload_byte;
		logic              payload_valid;
		logic [LEN_W-1:0]  frame_length;
	} result_t;

endpackage

`default_nettype wire

### hdl/framed_packet_receiver_checksum_top.sv
// an accepted item passes the input register, then the result register, before its result shows
// throughput: one item per cycle, sustained, as long as out_ready stays high
// the parse state steps once per item as it moves from the input register to the result register
// reset (arst_n low, asynchronous): both stages empty, parser waits for an id byte,
// frame_id clears to 0 and max_length sets to 65535
// top level: handshake stages and config registers around the frame parser; depends on frpc_pkg, frpc_parser
`default_nettype none

module framed_packet_receiver_checksum_top
	import frpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// config write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input item channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	// result item channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [STAT_W-1:0]         status,
	output logic [BYTE_W-1:0]         payload_byte,
	output logic                      payload_valid,
	output logic [LEN_W-1:0]          frame_length
);

	// config registers
	cfg_t cfg_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result stage
	logic              valid_s2;
	result_t           res_s2;
	result_t           res_c;

	logic adv_s2;   // result register can take a new item
	logic step;     // item moves from input register to result register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_id   <= FRAME_ID_RST;
			cfg_q.max_length <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_ID:   cfg_q.frame_id   <= cfg_data[BYTE_W-1:0];
				CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// result register is empty or is being drained this cycle
	assign adv_s2   = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv_s2;
	// input register takes a new item whenever it is empty or moving on
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	// per-byte decode and frame state
	frpc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_c;
	end

	assign out_valid     = valid_s2;
	assign status        = res_s2.status;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_valid = res_s2.payload_valid;
	assign frame_length  = res_s2.frame_length;

endmodule

`default_nettype wire

### hdl/frpc_parser.sv
// frame parser: phase, length, count and checksum state plus per-byte decode
// depends on frpc_pkg
`default_nettype none

module frpc_parser
	import frpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire cfg_t              cfg,
	output result_t                res
);

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [LEN_W-1:0]  full_len;
	logic [LEN_W-1:0]  cnt_inc;

	assign full_len = {rx_byte, len_q[BYTE_W-1:0]};
	assign cnt_inc  = cnt_q + LEN_W'(1);

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		res     = '{status: ST_BUSY, payload_byte: '0, payload_valid: 1'b0,
			frame_length: '0};
		unique case (phase_q)
			PH_LEN_LO: begin
				len_d   = LEN_W'(rx_byte);
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if (full_len > cfg.max_length) begin
					res.status = ST_TOOLONG;
					phase_d    = PH_ID;
					len_d      = '0;
					cnt_d      = '0;
					sum_d      = '0;
				end else begin
					len_d   = full_len;
					cnt_d   = '0;
					sum_d   = '0;
					// empty payload goes straight to the checksum byte
					phase_d = (full_len == '0) ? PH_CHK : PH_DATA;
				end
			end
			PH_DATA: begin
				sum_d             = sum_q + rx_byte;
				cnt_d             = cnt_inc;
				res.payload_byte  = rx_byte;
				res.payload_valid = 1'b1;
				if (cnt_inc == len_q)
					phase_d = PH_CHK;
			end
			PH_CHK: begin
				if (sum_q == rx_byte) begin
					res.status       = ST_DONE;
					res.frame_length = len_q;
				end else begin
					res.status = ST_BAD_SUM;
				end
				phase_d = PH_ID;
				len_d   = '0;
				cnt_d   = '0;
				sum_d   = '0;
			end
			default: begin
				// id byte, also any stray phase code
				len_d   = '0;
				cnt_d   = '0;
				sum_d   = '0;
				if (rx_byte == cfg.frame_id) begin
					phase_d = PH_LEN_LO;
				end else begin
					res.status = ST_BAD_ID;
					phase_d    = PH_ID;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
		end
	end

endmodule

`default_nettype wire

### hdl/frpc_checker.sv
// port-level checks for the framed packet receiver, bound to the top level
// depends on frpc_pkg and framed_packet_receiver_checksum_top
`default_nettype none

module frpc_checker
	import frpc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [STAT_W-1:0] status,
	input wire logic [BYTE_W-1:0] payload_byte,
	input wire logic              payload_valid,
	input wire logic [LEN_W-1:0]  frame_length
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(payload_byte) && $stable(payload_valid) && $stable(frame_length))
		else $error("result changed while stalled");

	// input side only stalls when a result is waiting downstream
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// payload bytes only come out while a frame is in progress
	a_payload_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> status == ST_BUSY)
		else $error("payload byte with a final status");

	// length is reported only for a good frame
	a_len_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> frame_length == '0)
		else $error("frame length without frame done");

	// non-payload results carry a zero byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == '0)
		else $error("payload byte set without payload valid");

endmodule

bind framed_packet_receiver_checksum_top frpc_checker u_frpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.payload_byte  (payload_byte),
	.payload_valid (payload_valid),
	.frame_length  (frame_length)
);

`default_nettype wire

### tb/framed_packet_receiver_checksum_top_test.sv
// self-checking testbench for framed_packet_receiver_checksum_top: directed rows, then random frames
// depends on frpc_pkg and the framed_packet_receiver_checksum_top rtl
`timescale 1ns / 100ps

module framed_packet_receiver_checksum_top_test;
	import frpc_pkg::*;

	localparam int NUM_PHASES  = 6;
	localparam int PHASE_BYTES = 190;
	localparam int HOLD_AT     = 300;    // results seen before the long receiver hold-off
	localparam int LONG_HOLD   = 400;    // cycles of out_ready low during the hold-off
	localparam int SETTLE      = 4;      // cycles of quiet after the last result
	localparam int CYCLE_LIMIT = 300000;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	// one row of the directed table: a byte (checked by prediction or by a typed
	// result) or a register write done while the block is idle
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic                 fixed;
		result_t              res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STAT_W-1:0]    status;
	logic [BYTE_W-1:0]    payload_byte;
	logic                 payload_valid;
	logic [LEN_W-1:0]     frame_length;

	// predictor copy of the parser state and the config registers
	phase_t            pr_phase;
	logic [LEN_W-1:0]  pr_len;
	logic [LEN_W-1:0]  pr_count;
	logic [BYTE_W-1:0] pr_sum;
	logic [BYTE_W-1:0] cfg_frame_id;
	logic [LEN_W-1:0]  cfg_max_len;

	result_t   pending_results [$];   // expected parse results, oldest first
	stim_row_t dir_rows [$];
	int        mismatch_count = 0;
	int        results_seen = 0;
	int        bytes_sent = 0;
	int        cycle_count = 0;
	int        gap_max = 0;           // 0 means the sender never pauses between bursts
	int        burst_left = 0;

	framed_packet_receiver_checksum_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.frame_length  (frame_length)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		$display("ERROR: %s", msg);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------

	function automatic void restart_parse();
		pr_phase = PH_ID;
		pr_len   = '0;
		pr_count = '0;
		pr_sum   = '0;
	endfunction

	// advance the parser by one received byte and return its result item
	function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		r.status        = ST_BUSY;
		r.payload_byte  = '0;
		r.payload_valid = 1'b0;
		r.frame_length  = '0;
		case (pr_phase)
			PH_LEN_LO: begin
				pr_len   = {8'h00, b};
				pr_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				// little endian: high byte completes the length, checked here
				pr_len = {b, pr_len[7:0]};
				if (pr_len > cfg_max_len) begin
					r.status = ST_TOOLONG;
					restart_parse();
				end else begin
					pr_count = '0;
					pr_sum   = '0;
					// empty payload goes straight to the checksum byte
					pr_phase = (pr_len == 0) ? PH_CHK : PH_DATA;
				end
			end
			PH_DATA: begin
				pr_sum          = pr_sum + b;
				pr_count        = pr_count + 1'b1;
				r.payload_byte  = b;
				r.payload_valid = 1'b1;
				if (pr_count == pr_len)
					pr_phase = PH_CHK;
			end
			PH_CHK: begin
				if (pr_sum == b) begin
					r.status       = ST_DONE;
					r.frame_length = pr_len;
				end else begin
					r.status = ST_BAD_SUM;
				end
				restart_parse();
			end
			default: begin
				// waiting for id; a wrong id is dropped, not reused
				if (b == cfg_frame_id) begin
					pr_len   = '0;
					pr_count = '0;
					pr_sum   = '0;
					pr_phase = PH_LEN_LO;
				end else begin
					r.status = ST_BAD_ID;
					restart_parse();
				end
			end
		endcase
		return r;
	endfunction

	// random filler byte; a zero length high byte keeps a frame that noise
	// happens to open down to at most 255 payload bytes
	function automatic logic [BYTE_W-1:0] filler_byte();
		return (pr_phase == PH_LEN_HI) ? 8'h00 : 8'($urandom);
	endfunction

	// ---------------------------------------------------------------------
	// directed table rows
	// ---------------------------------------------------------------------

	function automatic stim_row_t known_row(input logic [BYTE_W-1:0] b, input status_t st,
		input logic [BYTE_W-1:0] pb, input logic pv, input logic [LEN_W-1:0] fl);
		stim_row_t row;
		row.kind                = ROW_BYTE;
		row.idx                 = '0;
		row.data                = {8'h00, b};
		row.fixed               = 1'b1;
		row.res.status          = st;
		row.res.payload_byte    = pb;
		row.res.payload_valid   = pv;
		row.res.frame_length    = fl;
		return row;
	endfunction

	function automatic stim_row_t open_row(input logic [BYTE_W-1:0] b);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_BYTE;
		row.data  = {8'h00, b};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] val);
		stim_row_t row;
		row      = '0;
		row.kind = ROW_CFG;
		row.idx  = idx;
		row.data = val;
		return row;
	endfunction

	// ---------------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------------

	// offer one item, hold it until accepted, then record its expected result
	task automatic push_byte(input logic [BYTE_W-1:0] b, input bit fixed = 1'b0,
		input result_t fixed_res = '0);
		result_t predicted;
		if (gap_max != 0 && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = parse_byte(b);
		pending_results.push_back(fixed ? fixed_res : predicted);
		bytes_sent++;
	endtask

	// drain: stop offering and wait for every pending result, then a short settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FRAME_ID)
			cfg_frame_id = val[BYTE_W-1:0];
		else
			cfg_max_len = val;
	endtask

	// one frame with random payload; optionally a wrong id, a wrong checksum,
	// or cut short after keep bytes (keep < 0 sends it whole)
	task automatic send_frame(input int len, input bit wrong_id, input bit wrong_sum,
		input int keep);
		logic [BYTE_W-1:0] fr [$];
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		int n_pay;
		sum = 8'h00;
		fr.push_back(wrong_id ? (cfg_frame_id ^ 8'($urandom_range(1, 255))) : cfg_frame_id);
		fr.push_back(len[7:0]);
		fr.push_back(len[15:8]);
		// a too-long length stops the frame at its high byte
		n_pay = (len > cfg_max_len) ? 0 : len;
		for (int i = 0; i < n_pay; i++) begin
			b   = 8'($urandom);
			sum = sum + b;
			fr.push_back(b);
		end
		if (len <= cfg_max_len)
			fr.push_back(wrong_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
		// after a wrong id the rest is noise, kept from opening a huge frame
		foreach (fr[i])
			if (keep < 0 || i < keep)
				push_byte((wrong_id && pr_phase == PH_LEN_HI) ? 8'h00 : fr[i]);
	endtask

	// ---------------------------------------------------------------------
	// result side: checker and receiver stalls
	// ---------------------------------------------------------------------

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with nothing pending", results_seen));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_error($sformatf("result %0d status got %0d want %0d",
						results_seen, status, want.status));
				if (payload_byte !== want.payload_byte)
					report_error($sformatf("result %0d payload_byte got %02h want %02h",
						results_seen, payload_byte, want.payload_byte));
				if (payload_valid !== want.payload_valid)
					report_error($sformatf("result %0d payload_valid got %0b want %0b",
						results_seen, payload_valid, want.payload_valid));
				if (frame_length !== want.frame_length)
					report_error($sformatf("result %0d frame_length got %0d want %0d",
						results_seen, frame_length, want.frame_length));
			end
		end
	end

	// receiver: a rotating ready mask, reshaped now and then, plus one long
	// hold-off so the two stages fill and in_ready drops while items keep coming
	initial begin : result_sink
		logic [15:0] ready_mask;
		int cyc;
		bit held;
		ready_mask = 16'hFFFF;
		cyc        = 0;
		held       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (cyc % 300 == 0) begin
					case ($urandom_range(0, 3))
						0: ready_mask = 16'hFFFF;                              // no stalls
						1: ready_mask = 16'($urandom) | 16'h0001;
						2: ready_mask = 16'($urandom) | 16'($urandom) | 16'h0001;
						default: ready_mask = (16'($urandom) & 16'($urandom)) | 16'h0001;
					endcase
				end
				ready_mask = {ready_mask[0], ready_mask[15:1]};
				out_ready <= ready_mask[0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------

	initial begin : stimulus
		int ph;
		int len;
		int pick;
		int budget;
		logic [BYTE_W-1:0] id;
		logic [LEN_W-1:0]  ml;

		cfg_frame_id = FRAME_ID_RST;
		cfg_max_len  = MAX_LENGTH_RST;
		restart_parse();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: id 0, max length 65535
		dir_rows.push_back(known_row(8'h55, ST_BAD_ID, 8'h00, 1'b0, 16'd0));
		// zero length frame goes straight to the checksum byte
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h00, ST_DONE, 8'h00, 1'b0, 16'd0));
		// empty payload with a nonzero checksum
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h01, ST_BAD_SUM, 8'h00, 1'b0, 16'd0));
		// top id, max length 3; upper data bits of the id write are ignored
		dir_rows.push_back(cfg_row(CFG_FRAME_ID, 16'hC3FF));
		dir_rows.push_back(cfg_row(CFG_MAX_LENGTH, 16'd3));
		dir_rows.push_back(known_row(8'h00, ST_BAD_ID, 8'h00, 1'b0, 16'd0));
		// length equal to the maximum is accepted
		dir_rows.push_back(known_row(8'hFF, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h03, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'hFF, ST_BUSY, 8'hFF, 1'b1, 16'd0));
		dir_rows.push_back(known_row(8'h80, ST_BUSY, 8'h80, 1'b1, 16'd0));
		dir_rows.push_back(known_row(8'h01, ST_BUSY, 8'h01, 1'b1, 16'd0));
		dir_rows.push_back(open_row(8'h80));      // sum wraps modulo 256
		// length 256 through the high byte, over the maximum
		dir_rows.push_back(known_row(8'hFF, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h00, ST_BUSY, 8'h00, 1'b0, 16'd0));
		dir_rows.push_back(known_row(8'h01, ST_TOOLONG, 8'h00, 1'b0, 16'd0));
		// max length lowered in the middle of a frame, before its high byte
		dir_rows.push_back(cfg_row(CFG_FRAME_ID, 16'h3CA5));
		dir_rows.push_back(cfg_row(CFG_MAX_LENGTH, 16'hFFFF));
		dir_rows.push_back(open_row(8'hA5));
		dir_rows.push_back(open_row(8'h02));
		dir_rows.push_back(cfg_row(CFG_MAX_LENGTH, 16'd1));
		dir_rows.push_back(known_row(8'h00, ST_TOOLONG, 8'h00, 1'b0, 16'd0));

		gap_max = 3;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				push_byte(dir_rows[i].data[BYTE_W-1:0], dir_rows[i].fixed, dir_rows[i].res);
			end
		end

		// random part: several register settings, extremes included
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			id = 8'($urandom);
			case (ph)
				0: begin id = 8'h00; ml = 16'hFFFF; end
				1: begin id = 8'hFF; ml = 16'h0000; end
				2: ml = 16'($urandom_range(0, 40));
				3: ml = 16'hFFFF;
				4: ml = 16'($urandom);
				default: ml = 16'($urandom_range(8, 300));
			endcase
			write_reg(CFG_FRAME_ID, {8'($urandom), id});
			write_reg(CFG_MAX_LENGTH, ml);
			// first phase runs back to back, the rest with bursts and gaps
			gap_max    = (ph == 0) ? 0 : $urandom_range(2, 8);
			burst_left = 0;
			budget     = bytes_sent + PHASE_BYTES;
			while (bytes_sent < budget) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					// line noise between frames
					repeat ($urandom_range(1, 4)) push_byte(filler_byte());
				end else begin
					// finish whatever a cut frame left open before a clean start
					while (pr_phase != PH_ID)
						push_byte(filler_byte());
					pick = $urandom_range(0, 99);
					if (pick < 60)
						len = $urandom_range(0, 8);
					else if (pick < 92)
						len = $urandom_range(9, 40);
					else
						len = $urandom_range(100, 300);
					if ($urandom_range(0, 9) == 0 && cfg_max_len != 16'hFFFF)
						len = $urandom_range(int'(cfg_max_len) + 1, 65535);
					else if (len > cfg_max_len)
						len = cfg_max_len;
					send_frame(len, $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0,
						($urandom_range(0, 19) == 0) ? $urandom_range(1, len + 3) : -1);
				end
			end
		end

		// all stimulus in: wait for the last results, then a few quiet cycles
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
